[rtl/ppp_pkg.sv]
// ---------------------------------------------------------------------------
// ppp_pkg
// Shared item types, register indexes, sine table and saturation helpers for
// the perspective point projector.
// ---------------------------------------------------------------------------
package ppp_pkg;

    // input item: one 3D point
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               end_of_batch;
    } point_t;

    // result item: one screen position
    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] depth_scale;
        logic               divide_fault;
        logic               end_of_batch_out;
    } result_t;

    // item handed from the transform part to the divide part
    typedef struct packed {
        logic signed [63:0] num_x;
        logic signed [63:0] num_y;
        logic signed [32:0] divisor;
        logic               end_of_batch;
    } proj_t;

    // one lane of the restoring divider
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] bits;
        logic        ovf;
        logic        neg;
    } lane_t;

    // sign and magnitude of a table sine, magnitude in Q2.30
    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } trig_t;

    // configuration register indexes
    localparam logic [2:0] REG_ANGLE_X  = 3'd0;
    localparam logic [2:0] REG_ANGLE_Y  = 3'd1;
    localparam logic [2:0] REG_ANGLE_Z  = 3'd2;
    localparam logic [2:0] REG_OFFSET_X = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y = 3'd4;
    localparam logic [2:0] REG_OFFSET_Z = 3'd5;
    localparam logic [2:0] REG_VIEW     = 3'd6;
    localparam logic [2:0] REG_ZOOM     = 3'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = 32;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [39:0] SAT_HI  = 40'sh00_7FFF_FFFF;
    localparam logic signed [39:0] SAT_LO  = -40'sh00_8000_0000;

    // pi/180 in Q2.30
    localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;

    typedef logic [30:0] sin_rom_t [0:90];

    // quotient by shift and subtract, evaluated only while the table is built
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned dv);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], n[i]};
            if (rem >= dv)
            begin
                rem  = rem - dv;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // first quadrant sine in Q2.30 from a ten-term series
    function automatic sin_rom_t build_sin_rom();
        sin_rom_t       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned div;
        longint         sum;
        for (int deg = 0; deg <= 90; deg++) begin
            x    = longint'(deg) * RAD_PER_DEG_Q30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 9; k++) begin
                div  = longint'((2 * k) * (2 * k + 1));
                term = udiv64((term * x2) >> 30, div);
                if ((k % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > (64'sd1 <<< 30))
                sum = 64'sd1 <<< 30;
            rom[deg] = sum[30:0];
        end
        return rom;
    endfunction

    localparam sin_rom_t SIN_ROM = build_sin_rom();

    // sine of 0..449 degrees by quadrant mirroring
    function automatic trig_t trig_lookup(input logic [9:0] deg);
        logic [9:0] d;
        logic [6:0] idx;
        trig_t      r;
        d     = (deg >= 10'd360) ? deg - 10'd360 : deg;
        r.neg = 1'b0;
        if (d <= 10'd90) begin
            idx = d[6:0];
        end
        else if (d <= 10'd180) begin
            idx = 7'(10'd180 - d);
        end
        else if (d <= 10'd270) begin
            idx   = 7'(d - 10'd180);
            r.neg = 1'b1;
        end
        else begin
            idx   = 7'(10'd360 - d);
            r.neg = 1'b1;
        end
        r.mag = SIN_ROM[idx];
        return r;
    endfunction

    // clamp to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = S32_MAX;
        else if (v < SAT_LO)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/ppp_fifo.sv]
// ---------------------------------------------------------------------------
// ppp_fifo
// Small register queue; head item visible while not empty.
// ---------------------------------------------------------------------------
module ppp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    // status and head item
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count not lowered by pop");

endmodule

[rtl/ppp_front.sv]
// ---------------------------------------------------------------------------
// ppp_front
// Transform part: negate, rotate about Z, X, Y, translate, then form the
// zoomed numerators and the perspective divisor.
// ---------------------------------------------------------------------------
module ppp_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  ppp_pkg::point_t            point,
    output logic                       full,
    input  logic signed [FRAC_BITS+1:0] sin_x,
    input  logic signed [FRAC_BITS+1:0] cos_x,
    input  logic signed [FRAC_BITS+1:0] sin_y,
    input  logic signed [FRAC_BITS+1:0] cos_y,
    input  logic signed [FRAC_BITS+1:0] sin_z,
    input  logic signed [FRAC_BITS+1:0] cos_z,
    input  logic signed [31:0]         offset_x,
    input  logic signed [31:0]         offset_y,
    input  logic signed [31:0]         offset_z,
    input  logic signed [31:0]         view_distance,
    input  logic [30:0]                zoom_factor,
    output logic                       mid_push,
    output ppp_pkg::proj_t             mid_item,
    input  logic                       mid_full
);
    import ppp_pkg::*;

    localparam int TW = FRAC_BITS + 2;
    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

    logic        en, take;
    logic [8:0]  valid_reg;
    logic [8:0]  eob_reg;

    logic signed [32:0]      x0_reg, y0_reg, z0_reg, x0_next, y0_next, z0_next;
    logic signed [32+TW:0]   p1a_reg, p1b_reg, p1c_reg, p1d_reg;
    logic signed [32:0]      z1c_reg;
    logic signed [33:0]      x1_reg, y1_reg, z1_reg, x1_next, y1_next;
    logic signed [33+TW:0]   p3a_reg, p3b_reg, p3c_reg, p3d_reg;
    logic signed [33:0]      x3c_reg;
    logic signed [34:0]      x2_reg, y2_reg, z2_reg, y2_next, z2_next;
    logic signed [34+TW:0]   p5a_reg, p5b_reg, p5c_reg, p5d_reg;
    logic signed [34:0]      y5c_reg;
    logic signed [35:0]      x3_reg, y3_reg, z3_reg, x3_next, z3_next;
    logic signed [31:0]      x4_reg, y4_reg, z4_reg;
    proj_t                   out_reg, out_next;
    logic signed [63:0]      sum_a, sum_b, sum_c, sum_d, sum_e, sum_f;

    // the pipe moves unless a finished item waits on a full queue
    assign en       = !valid_reg[8] || !mid_full;
    assign full     = !en;
    assign take     = push && en;
    assign mid_push = valid_reg[8] && !mid_full;
    assign mid_item = out_reg;

    // negate y and z
    always_comb
    begin
        x0_next = 33'(point.point_x);
        y0_next = -33'(point.point_y);
        z0_next = -33'(point.point_z);
    end

    // rotation sums with round to nearest, ties up
    always_comb
    begin
        sum_a   = 64'(p1a_reg) - 64'(p1b_reg) + RND;
        sum_b   = 64'(p1c_reg) + 64'(p1d_reg) + RND;
        x1_next = 34'(sum_a >>> FRAC_BITS);
        y1_next = 34'(sum_b >>> FRAC_BITS);
        sum_c   = 64'(p3a_reg) + 64'(p3b_reg) + RND;
        sum_d   = 64'(p3c_reg) - 64'(p3d_reg) + RND;
        y2_next = 35'(sum_c >>> FRAC_BITS);
        z2_next = 35'(sum_d >>> FRAC_BITS);
        sum_e   = 64'(p5a_reg) + 64'(p5b_reg) + RND;
        sum_f   = 64'(p5c_reg) - 64'(p5d_reg) + RND;
        x3_next = 36'(sum_e >>> FRAC_BITS);
        z3_next = 36'(sum_f >>> FRAC_BITS);
    end

    // numerators and divisor
    always_comb
    begin
        out_next.num_x        = x4_reg * $signed({1'b0, zoom_factor});
        out_next.num_y        = y4_reg * $signed({1'b0, zoom_factor});
        out_next.divisor      = 33'(view_distance) - 33'(z4_reg);
        out_next.end_of_batch = eob_reg[7];
    end

    // item valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[7:0], take};
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eob_reg <= {eob_reg[7:0], point.end_of_batch};
            x0_reg  <= x0_next;
            y0_reg  <= y0_next;
            z0_reg  <= z0_next;
            // about Z
            p1a_reg <= x0_reg * cos_z;
            p1b_reg <= y0_reg * sin_z;
            p1c_reg <= x0_reg * sin_z;
            p1d_reg <= y0_reg * cos_z;
            z1c_reg <= z0_reg;
            x1_reg  <= x1_next;
            y1_reg  <= y1_next;
            z1_reg  <= 34'(z1c_reg);
            // about X
            p3a_reg <= y1_reg * cos_x;
            p3b_reg <= z1_reg * sin_x;
            p3c_reg <= z1_reg * cos_x;
            p3d_reg <= y1_reg * sin_x;
            x3c_reg <= x1_reg;
            x2_reg  <= 35'(x3c_reg);
            y2_reg  <= y2_next;
            z2_reg  <= z2_next;
            // about Y
            p5a_reg <= x2_reg * cos_y;
            p5b_reg <= z2_reg * sin_y;
            p5c_reg <= z2_reg * cos_y;
            p5d_reg <= x2_reg * sin_y;
            y5c_reg <= y2_reg;
            x3_reg  <= x3_next;
            y3_reg  <= 36'(y5c_reg);
            z3_reg  <= z3_next;
            // translate
            x4_reg  <= sat32(40'(x3_reg) + 40'(offset_x));
            y4_reg  <= sat32(40'(y3_reg) + 40'(offset_y));
            z4_reg  <= sat32(40'(z3_reg) + 40'(offset_z));
            out_reg <= out_next;
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[8] && mid_full |=> valid_reg[8] && $stable(out_reg))
        else $error("finished item changed while queue full");

endmodule

[rtl/ppp_back.sv]
// ---------------------------------------------------------------------------
// ppp_back
// Divide part: three restoring dividers with round to nearest, then
// saturation, screen centering and the zero divisor case.
// ---------------------------------------------------------------------------
module ppp_back #(
    parameter int FRAC_BITS     = 16,
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mid_empty,
    input  ppp_pkg::proj_t   mid_item,
    output logic             mid_pop,
    output logic             out_push,
    output ppp_pkg::result_t out_item,
    input  logic             out_full
);
    import ppp_pkg::*;

    localparam logic signed [39:0] CX = 40'sd1 * (SCREEN_WIDTH / 2) * (40'sd1 <<< FRAC_BITS);
    localparam logic signed [39:0] CY = 40'sd1 * (SCREEN_HEIGHT / 2) * (40'sd1 <<< FRAC_BITS);
    localparam logic [63:0]        ONE_SQ = 64'd1 << (2 * FRAC_BITS);

    typedef struct packed {
        logic fault;
        logic neg_x;
        logic zero_x;
        logic neg_y;
        logic zero_y;
        logic eob;
    } side_t;

    logic               en;
    logic               b0_valid_reg, b1_valid_reg, e0_valid_reg, e1_valid_reg;
    logic [DIV_STEPS:0] dv_valid_reg;

    logic [31:0]        b0_ud_reg, b0_ud_next, b1_ud_reg;
    logic [63:0]        b0_un_reg [3];
    logic [63:0]        b0_un_next [3];
    logic [63:0]        b1_nr_reg [3];
    logic [2:0]         b0_neg_reg, b0_neg_next, b1_neg_reg;
    side_t              b0_side_reg, b0_side_next, b1_side_reg;
    lane_t              dv_lane_reg [DIV_STEPS+1][3];
    logic [31:0]        dv_ud_reg [DIV_STEPS+1];
    side_t              dv_side_reg [DIV_STEPS+1];
    logic signed [31:0] e0_val_reg [3];
    logic signed [31:0] e0_val_next [3];
    side_t              e0_side_reg;
    result_t            e1_item_reg, e1_item_next;

    // one quotient bit per step
    function automatic lane_t div_step(input lane_t a, input logic [31:0] ud);
        logic [32:0] t;
        logic        ge;
        lane_t       r;
        t      = {a.rem, a.bits[31]};
        ge     = (t >= {1'b0, ud});
        r      = a;
        r.rem  = ge ? 32'(t - {1'b0, ud}) : t[31:0];
        r.bits = {a.bits[30:0], ge};
        return r;
    endfunction

    // handshakes
    assign en       = !e1_valid_reg || !out_full;
    assign mid_pop  = en && !mid_empty;
    assign out_push = e1_valid_reg && !out_full;
    assign out_item = e1_item_reg;

    // magnitudes and signs
    always_comb
    begin
        b0_ud_next    = mid_item.divisor[32] ? 32'(-mid_item.divisor)
                                             : mid_item.divisor[31:0];
        b0_un_next[0] = mid_item.num_x[63] ? 64'(-mid_item.num_x) : mid_item.num_x;
        b0_un_next[1] = mid_item.num_y[63] ? 64'(-mid_item.num_y) : mid_item.num_y;
        b0_un_next[2] = ONE_SQ;
        b0_neg_next   = {mid_item.divisor[32],
                         mid_item.num_y[63] ^ mid_item.divisor[32],
                         mid_item.num_x[63] ^ mid_item.divisor[32]};
        b0_side_next.fault  = (mid_item.divisor == '0);
        b0_side_next.neg_x  = mid_item.num_x[63];
        b0_side_next.zero_x = (mid_item.num_x == '0);
        b0_side_next.neg_y  = mid_item.num_y[63];
        b0_side_next.zero_y = (mid_item.num_y == '0);
        b0_side_next.eob    = mid_item.end_of_batch;
    end

    // signed quotient, clamped
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (dv_lane_reg[DIV_STEPS][l].ovf)
                e0_val_next[l] = dv_lane_reg[DIV_STEPS][l].neg ? S32_MIN : S32_MAX;
            else if (dv_lane_reg[DIV_STEPS][l].neg)
                e0_val_next[l] = sat32(-40'($signed({1'b0, dv_lane_reg[DIV_STEPS][l].bits})));
            else
                e0_val_next[l] = sat32(40'($signed({1'b0, dv_lane_reg[DIV_STEPS][l].bits})));
        end
    end

    // centering and zero divisor
    always_comb
    begin
        e1_item_next.end_of_batch_out = e0_side_reg.eob;
        e1_item_next.divide_fault     = e0_side_reg.fault;
        if (e0_side_reg.fault)
        begin
            e1_item_next.depth_scale = S32_MAX;
            e1_item_next.screen_x = e0_side_reg.neg_x  ? S32_MIN :
                                    e0_side_reg.zero_x ? sat32(CX) : S32_MAX;
            e1_item_next.screen_y = e0_side_reg.neg_y  ? S32_MIN :
                                    e0_side_reg.zero_y ? sat32(CY) : S32_MAX;
        end
        else
        begin
            e1_item_next.depth_scale = e0_val_reg[2];
            e1_item_next.screen_x    = sat32(40'(e0_val_reg[0]) + CX);
            e1_item_next.screen_y    = sat32(40'(e0_val_reg[1]) + CY);
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg <= 1'b0;
            b1_valid_reg <= 1'b0;
            dv_valid_reg <= '0;
            e0_valid_reg <= 1'b0;
            e1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b0_valid_reg <= !mid_empty;
            b1_valid_reg <= b0_valid_reg;
            dv_valid_reg <= {dv_valid_reg[DIV_STEPS-1:0], b1_valid_reg};
            e0_valid_reg <= dv_valid_reg[DIV_STEPS];
            e1_valid_reg <= e0_valid_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_ud_reg   <= b0_ud_next;
            b0_un_reg   <= b0_un_next;
            b0_neg_reg  <= b0_neg_next;
            b0_side_reg <= b0_side_next;
            // add half the divisor for rounding
            b1_ud_reg   <= b0_ud_reg;
            b1_neg_reg  <= b0_neg_reg;
            b1_side_reg <= b0_side_reg;
            for (int l = 0; l < 3; l++)
                b1_nr_reg[l] <= b0_un_reg[l] + 64'(b0_ud_reg >> 1);
            // load dividers, flag quotients of 2^32 and up
            for (int l = 0; l < 3; l++)
            begin
                dv_lane_reg[0][l].rem  <= b1_nr_reg[l][63:32];
                dv_lane_reg[0][l].bits <= b1_nr_reg[l][31:0];
                dv_lane_reg[0][l].ovf  <= (b1_nr_reg[l][63:32] >= b1_ud_reg);
                dv_lane_reg[0][l].neg  <= b1_neg_reg[l];
            end
            dv_ud_reg[0]   <= b1_ud_reg;
            dv_side_reg[0] <= b1_side_reg;
            // divider steps
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                for (int l = 0; l < 3; l++)
                    dv_lane_reg[j+1][l] <= div_step(dv_lane_reg[j][l], dv_ud_reg[j]);
                dv_ud_reg[j+1]   <= dv_ud_reg[j];
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
            e0_val_reg  <= e0_val_next;
            e0_side_reg <= dv_side_reg[DIV_STEPS];
            e1_item_reg <= e1_item_next;
        end
    end

    a_fault_scale: assert property (@(posedge clk) disable iff (!rst_n)
        e1_valid_reg && e1_item_reg.divide_fault |-> e1_item_reg.depth_scale == S32_MAX)
        else $error("zero divisor without saturated scale");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        e1_valid_reg && out_full |=> e1_valid_reg && $stable(e1_item_reg))
        else $error("finished result changed while output queue full");

endmodule

[rtl/perspective_point_projector_top.sv]
// ---------------------------------------------------------------------------
// perspective_point_projector_top
// Rotates, translates and perspective-projects one 3D point per item.
// ---------------------------------------------------------------------------
// One point is accepted every clock cycle while full is low, and one result
// comes out for each, in order. A point's result reaches the result queue
// after nine stages of transform (input register, three rotations, each a
// multiply stage and a round stage, translation and the zoom multiply), the
// two-entry queue, then 37 stages in the divide part, dominated by the 32
// steps of the pipelined restoring dividers that form screen x, screen y and
// the depth scale.
// Angles (low nine bits) are taken modulo 360 and turned into sine and cosine when written.
module perspective_point_projector_top #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int FRAC_BITS     = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ppp_pkg::point_t  point,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output ppp_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import ppp_pkg::*;

    localparam int TW = FRAC_BITS + 2;
    localparam logic signed [TW-1:0] TRIG_ONE = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic [31:0]          TRIG_RND = 32'd1 << (29 - FRAC_BITS);

    logic signed [TW-1:0] sin_x_reg, cos_x_reg, sin_y_reg, cos_y_reg;
    logic signed [TW-1:0] sin_z_reg, cos_z_reg;
    logic signed [31:0]   offset_x_reg, offset_y_reg, offset_z_reg, view_reg;
    logic [30:0]          zoom_reg;
    logic [8:0]           ang;
    logic [8:0]           ang_mod;
    trig_t                sin_q, cos_q;
    logic [31:0]          sin_r, cos_r;
    logic signed [TW-1:0] sin_next, cos_next;
    logic                 cfg_write;

    logic                 mid_push, mid_pop, mid_full, mid_empty;
    proj_t                mid_in, mid_out;
    logic [$bits(proj_t)-1:0] mid_raw;
    logic                 out_push, out_full;
    result_t              out_in;
    logic [$bits(result_t)-1:0] out_raw;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // sine and cosine of the written angle
    always_comb
    begin
        ang      = cfg_data[8:0];
        ang_mod  = (ang >= 9'd360) ? ang - 9'd360 : ang;
        sin_q    = trig_lookup({1'b0, ang_mod});
        cos_q    = trig_lookup({1'b0, ang_mod} + 10'd90);
        sin_r    = ({1'b0, sin_q.mag} + TRIG_RND) >> (30 - FRAC_BITS);
        cos_r    = ({1'b0, cos_q.mag} + TRIG_RND) >> (30 - FRAC_BITS);
        sin_next = sin_q.neg ? -$signed({1'b0, sin_r[FRAC_BITS:0]})
                             : $signed({1'b0, sin_r[FRAC_BITS:0]});
        cos_next = cos_q.neg ? -$signed({1'b0, cos_r[FRAC_BITS:0]})
                             : $signed({1'b0, cos_r[FRAC_BITS:0]});
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_x_reg    <= '0;
            cos_x_reg    <= TRIG_ONE;
            sin_y_reg    <= '0;
            cos_y_reg    <= TRIG_ONE;
            sin_z_reg    <= '0;
            cos_z_reg    <= TRIG_ONE;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
            view_reg     <= 32'sd655360;
            zoom_reg     <= 31'd65536;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ANGLE_X:
                begin
                    sin_x_reg <= sin_next;
                    cos_x_reg <= cos_next;
                end
                REG_ANGLE_Y:
                begin
                    sin_y_reg <= sin_next;
                    cos_y_reg <= cos_next;
                end
                REG_ANGLE_Z:
                begin
                    sin_z_reg <= sin_next;
                    cos_z_reg <= cos_next;
                end
                REG_OFFSET_X: offset_x_reg <= cfg_data;
                REG_OFFSET_Y: offset_y_reg <= cfg_data;
                REG_OFFSET_Z: offset_z_reg <= cfg_data;
                REG_VIEW:     view_reg     <= cfg_data;
                REG_ZOOM:     zoom_reg     <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // transform part
    ppp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .point         (point),
        .full          (full),
        .sin_x         (sin_x_reg),
        .cos_x         (cos_x_reg),
        .sin_y         (sin_y_reg),
        .cos_y         (cos_y_reg),
        .sin_z         (sin_z_reg),
        .cos_z         (cos_z_reg),
        .offset_x      (offset_x_reg),
        .offset_y      (offset_y_reg),
        .offset_z      (offset_z_reg),
        .view_distance (view_reg),
        .zoom_factor   (zoom_reg),
        .mid_push      (mid_push),
        .mid_item      (mid_in),
        .mid_full      (mid_full)
    );

    // queue between the parts
    ppp_fifo #(
        .WIDTH ($bits(proj_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_in),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_raw),
        .empty (mid_empty)
    );

    assign mid_out = proj_t'(mid_raw);

    // divide part
    ppp_back #(
        .FRAC_BITS     (FRAC_BITS),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (mid_out),
        .mid_pop   (mid_pop),
        .out_push  (out_push),
        .out_item  (out_in),
        .out_full  (out_full)
    );

    // result queue
    ppp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_raw),
        .empty (empty)
    );

    assign result = result_t'(out_raw);

endmodule
